// ===== rtl/bwa_pkg.sv =====
// ----------------------------------------------------------------------------
// bwa_pkg: shared types and constants of the beeper window-average sampler
// Holds the sequencer states, operation and register codes, the mixed level
// table and the fixed widths of times, levels and filter values.
// ----------------------------------------------------------------------------
`default_nettype none

package bwa_pkg;

    // operation codes carried in s_tuser
    localparam logic [1:0] OP_RECORD  = 2'd0;
    localparam logic [1:0] OP_TICK    = 2'd1;
    localparam logic [1:0] OP_BEGIN   = 2'd2;
    localparam logic [1:0] OP_RESTART = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_SAMPLE_PERIOD = 2'd0;
    localparam logic [1:0] CFG_DC_ALPHA      = 2'd1;
    localparam logic [1:0] CFG_SAMPLE_SCALE  = 2'd2;

    // register reset values
    localparam logic [31:0] PERIOD_RST = 32'd5201178;
    localparam logic [15:0] ALPHA_RST  = 16'd65522;
    localparam logic [15:0] SCALE_RST  = 16'd32767;

    // fixed widths
    localparam int TIME_W = 48;   // Q32.16 tacts
    localparam int RAW_W  = 17;   // unsigned Q16 level, up to 1.0
    localparam int FILT_W = 24;   // filter output, signed
    localparam int DEN_W  = 41;   // sum of shifted durations
    localparam int NUM_W  = 58;   // duration-weighted level sum
    localparam int QUO_W  = 17;   // average level bits

    // level of code 1 in Q16 (about 0.33 of full scale); code 2 is twice this
    localparam logic [14:0] LEVEL_THIRD = 15'd21627;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WALK_RD,
        ST_WALK_EV,
        ST_TAIL,
        ST_SUMS,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_DIV,
        ST_FILT_MUL,
        ST_FILT_ADD,
        ST_SCALE_MUL,
        ST_SCALE_SAT,
        ST_EMIT
    } state_t;

    // mixed level of a code (ear*2 + mic), Q16
    function automatic logic [RAW_W-1:0] bwa_level(input logic [1:0] code);
        logic [RAW_W-1:0] lv;
        case (code)
            2'd0:    lv = 17'd0;
            2'd1:    lv = 17'd21627;
            2'd2:    lv = 17'd43254;
            default: lv = 17'd65536;
        endcase
        return lv;
    endfunction

    // right shift that brings a window length below 2^40
    function automatic logic [3:0] bwa_norm_shift(input logic [TIME_W-1:0] total);
        logic [3:0] sh;
        sh = 4'd0;
        for (int i = 0; i < 8; i++) begin
            if (total[40+i]) begin
                sh = 4'(i + 1);
            end
        end
        return sh;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bwa_event_queue.sv =====
// ----------------------------------------------------------------------------
// bwa_event_queue: storage for queued level changes
// Single write port, single read port with registered read data. Each entry
// holds the tact and the level code of one change.
// ----------------------------------------------------------------------------
`default_nettype none

module bwa_event_queue #(
    parameter int DEPTH = 64,
    parameter int PTR_W = 6
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [PTR_W-1:0] wr_addr,
    input  wire logic [31:0]      wr_tact,
    input  wire logic [1:0]       wr_level,
    input  wire logic             rd_en,
    input  wire logic [PTR_W-1:0] rd_addr,
    output logic      [31:0]      rd_tact,
    output logic      [1:0]       rd_level
);

    logic [33:0] mem [DEPTH];
    logic [33:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {wr_level, wr_tact};
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_tact  = rd_data_reg[31:0];
    assign rd_level = rd_data_reg[33:32];

endmodule

`default_nettype wire

// ===== rtl/bwa_divider.sv =====
// ----------------------------------------------------------------------------
// bwa_divider: serial restoring divider for the window average
// One quotient bit per cycle. The quotient is known to fit in QUO_W bits,
// so the upper numerator bits load straight into the remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module bwa_divider
    import bwa_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output logic      [QUO_W-1:0] quot
);

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [DEN_W-1:0] rem_reg,  rem_next;
    logic [QUO_W-1:0] low_reg,  low_next;
    logic [QUO_W-1:0] quo_reg,  quo_next;
    logic [DEN_W-1:0] den_reg,  den_next;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;

    // one restoring step
    always_comb begin
        trial     = {rem_reg, low_reg[QUO_W-1]};
        diff      = trial - {1'b0, den_reg};
        rem_next  = rem_reg;
        low_next  = low_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = num[NUM_W-1 -: DEN_W];
            low_next  = num[QUO_W-1:0];
            den_next  = den;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = diff[DEN_W-1:0];
                quo_next = {quo_reg[QUO_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DEN_W-1:0];
                quo_next = {quo_reg[QUO_W-2:0], 1'b0};
            end
            low_next = {low_reg[QUO_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(QUO_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

`default_nettype wire

// ===== rtl/beeper_window_average_sampler.sv =====
// ----------------------------------------------------------------------------
// beeper_window_average_sampler: box-filter resampler with DC blocker
// Queues level changes, averages the mixed beeper level over each sample
// window weighted by duration, then DC-blocks, scales and saturates it.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  s_axis   | in        | tuser: operation; tdata: tact, ear, mic
//  m_axis   | out       | tuser: sample_lost; tdata: sample, index, overflow
//  cfg      | in        | cfg_index register, cfg_data value
//
//  record, begin-frame and restart transactions and ticks with no sample due
//  are handled in ST_IDLE; the work of a sample is set by the queue walk (one
//  memory read per event) and the serial divider.
//  s_tready is low while a sample is in work; a result waits in the output
//  register and a new transaction is taken while it stalls.
//  aresetn is synchronous; the queue memory needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module beeper_window_average_sampler
    import bwa_pkg::*;
#(
    parameter int QUEUE_DEPTH   = 64,
    parameter int FRAME_SAMPLES = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // [31:0] tact, [32] ear, [33] mic
    input  wire logic [1:0]  s_tuser,   // [1:0] operation
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // [15:0] sample, [25:16] sample_index,
                                        // [26] overflow_seen
    output logic             m_tuser,   // [0] sample_lost
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int FRM_W = $clog2(FRAME_SAMPLES + 1);

    state_t state_reg, state_next;

    // configuration
    logic [31:0] period_reg;
    logic [15:0] alpha_reg;
    logic [15:0] scale_reg;

    // queue and window state
    logic [PTR_W-1:0]  head_reg, tail_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg, walk_n_reg;
    logic [TIME_W-1:0] ws_time_reg, next_time_reg, cursor_reg;
    logic [1:0]        ws_level_reg, lv_reg;
    logic [FRM_W-1:0]  frame_cnt_reg;
    logic              lost_flag_reg;
    logic [TIME_W-1:0] dur_reg [4];

    // arithmetic pipeline registers
    logic [DEN_W-1:0]        den_reg;
    logic [42:0]             wsum_reg;
    logic [DEN_W-1:0]        s3_reg;
    logic [NUM_W-1:0]        num_reg;
    logic [RAW_W-1:0]        raw_reg;
    logic signed [17:0]      prev_in_reg;
    logic signed [FILT_W-1:0] prev_out_reg;
    logic signed [40:0]      fprod_reg;
    logic signed [FILT_W-1:0] fout_reg;
    logic [39:0]             sprod_reg;
    logic [15:0]             res_sample_reg;
    logic                    res_lost_reg;
    logic                    res_adv_reg;
    logic                    div_start_reg;
    logic [3:0]              norm_sh_reg;

    // output register
    logic        m_tvalid_reg;
    logic [15:0] m_sample_reg;
    logic [9:0]  m_index_reg;
    logic        m_lost_reg;
    logic        m_over_reg;

    // input fields
    logic [1:0]        in_op;
    logic [31:0]       in_tact;
    logic [1:0]        in_code;
    logic [TIME_W-1:0] in_time;
    logic              s_fire;
    logic              tick_due, frame_full, win_empty, q_full;
    logic              out_free;

    // queue read side
    logic              rd_en;
    logic [31:0]       rd_tact;
    logic [1:0]        rd_level;
    logic [TIME_W-1:0] ev_time;
    logic [TIME_W-1:0] ev_clamp;

    // divider
    logic             div_done;
    logic [QUO_W-1:0] div_quot;

    // sums
    logic [3:0]        norm_sh;
    logic [TIME_W-1:0] sh_dur [4];
    logic [48:0]       next_sum;

    // filter and scale
    logic signed [41:0] fb_round;
    logic signed [26:0] fsum;
    logic signed [FILT_W-1:0] fsat;
    logic [23:0]        fmag;
    logic [23:0]        sq;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign in_op    = s_tuser;
    assign in_tact  = s_tdata[31:0];
    assign in_code  = {s_tdata[32], s_tdata[33]};
    assign in_time  = {in_tact, 16'd0};
    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign tick_due   = (in_time >= next_time_reg);
    assign frame_full = (frame_cnt_reg >= FRM_W'(FRAME_SAMPLES));
    assign win_empty  = (next_time_reg <= ws_time_reg);
    assign q_full     = (count_reg >= CNT_W'(QUEUE_DEPTH));
    assign out_free   = !m_tvalid_reg || m_tready;

    // event storage
    bwa_event_queue #(
        .DEPTH (QUEUE_DEPTH),
        .PTR_W (PTR_W)
    ) u_queue (
        .aclk     (aclk),
        .wr_en    (s_fire && (in_op == OP_RECORD) && !q_full),
        .wr_addr  (tail_reg),
        .wr_tact  (in_tact),
        .wr_level (in_code),
        .rd_en    (rd_en),
        .rd_addr  (rd_ptr_reg),
        .rd_tact  (rd_tact),
        .rd_level (rd_level)
    );

    // average division
    bwa_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start_reg),
        .num     (num_reg),
        .den     (den_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    // queue walk helpers
    assign ev_time  = {rd_tact, 16'd0};
    assign ev_clamp = (ev_time < cursor_reg) ? cursor_reg : ev_time;

    // duration normalization, shift taken while the window start is still old
    assign norm_sh = bwa_norm_shift(next_time_reg - ws_time_reg);
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            sh_dur[k] = dur_reg[k] >> norm_sh_reg;
        end
    end

    assign next_sum = {1'b0, next_time_reg} + 49'(period_reg);

    // filter sum and saturation
    assign fb_round = (42'(fprod_reg) + 42'sd32768) >>> 16;
    assign fsum = 27'($signed({1'b0, raw_reg})) - 27'(prev_in_reg) + 27'(fb_round);
    always_comb begin
        if (fsum > 27'sd8388607) begin
            fsat = 24'sh7FFFFF;
        end else if (fsum < -27'sd8388608) begin
            fsat = 24'sh800000;
        end else begin
            fsat = fsum[FILT_W-1:0];
        end
    end
    assign fmag = fout_reg[FILT_W-1] ? 24'(-fout_reg) : 24'(fout_reg);
    assign sq   = sprod_reg[39:16];

    // next state
    always_comb begin
        state_next = state_reg;
        rd_en      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire && (in_op == OP_TICK) && tick_due) begin
                    if (frame_full) begin
                        state_next = ST_EMIT;
                    end else if (win_empty) begin
                        state_next = ST_FILT_MUL;
                    end else begin
                        state_next = ST_WALK_RD;
                    end
                end
            end
            ST_WALK_RD: begin
                if (walk_n_reg == count_reg) begin
                    state_next = ST_TAIL;
                end else begin
                    rd_en      = 1'b1;
                    state_next = ST_WALK_EV;
                end
            end
            ST_WALK_EV: begin
                state_next = (ev_time >= next_time_reg) ? ST_TAIL : ST_WALK_RD;
            end
            ST_TAIL:      state_next = ST_SUMS;
            ST_SUMS:      state_next = ST_MUL_LO;
            ST_MUL_LO:    state_next = (den_reg == '0) ? ST_FILT_MUL : ST_MUL_HI;
            ST_MUL_HI:    state_next = ST_DIV;
            ST_DIV:       state_next = div_done ? ST_FILT_MUL : ST_DIV;
            ST_FILT_MUL:  state_next = ST_FILT_ADD;
            ST_FILT_ADD:  state_next = ST_SCALE_MUL;
            ST_SCALE_MUL: state_next = ST_SCALE_SAT;
            ST_SCALE_SAT: state_next = ST_EMIT;
            ST_EMIT:      state_next = out_free ? ST_IDLE : ST_EMIT;
            default:      state_next = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= PERIOD_RST;
            alpha_reg  <= ALPHA_RST;
            scale_reg  <= SCALE_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_SAMPLE_PERIOD: period_reg <= cfg_data;
                CFG_DC_ALPHA:      alpha_reg  <= cfg_data[15:0];
                CFG_SAMPLE_SCALE:  scale_reg  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // control and window state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            ws_time_reg   <= '0;
            ws_level_reg  <= '0;
            next_time_reg <= TIME_W'(PERIOD_RST);
            frame_cnt_reg <= '0;
            prev_in_reg   <= '0;
            prev_out_reg  <= '0;
            lost_flag_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            div_start_reg <= 1'b0;
        end else begin
            div_start_reg <= 1'b0;
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        case (in_op)
                            OP_RECORD: begin
                                if (q_full) begin
                                    lost_flag_reg <= 1'b1;
                                end else begin
                                    tail_reg  <= ptr_inc(tail_reg);
                                    count_reg <= count_reg + 1'b1;
                                end
                            end
                            OP_TICK: begin
                                if (tick_due && frame_full) begin
                                    lost_flag_reg <= 1'b1;
                                end
                            end
                            OP_BEGIN: begin
                                frame_cnt_reg <= '0;
                                count_reg     <= '0;
                                head_reg      <= tail_reg;
                                ws_time_reg   <= in_time;
                                ws_level_reg  <= in_code;
                            end
                            OP_RESTART: begin
                                frame_cnt_reg <= '0;
                                count_reg     <= '0;
                                head_reg      <= tail_reg;
                                ws_time_reg   <= in_time;
                                ws_level_reg  <= in_code;
                                next_time_reg <= TIME_W'(period_reg);
                                prev_in_reg   <= '0;
                                prev_out_reg  <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                // consumed events leave the queue, window moves on
                ST_TAIL: begin
                    head_reg     <= rd_ptr_reg;
                    count_reg    <= count_reg - walk_n_reg;
                    ws_time_reg  <= next_time_reg;
                    ws_level_reg <= lv_reg;
                end
                ST_MUL_HI: begin
                    div_start_reg <= 1'b1;
                end
                ST_FILT_ADD: begin
                    prev_in_reg  <= $signed({1'b0, raw_reg});
                    prev_out_reg <= fsat;
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        if (res_adv_reg) begin
                            frame_cnt_reg <= frame_cnt_reg + 1'b1;
                            next_time_reg <= next_sum[TIME_W] ? '1 : next_sum[TIME_W-1:0];
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                cursor_reg   <= ws_time_reg;
                lv_reg       <= ws_level_reg;
                walk_n_reg   <= '0;
                rd_ptr_reg   <= head_reg;
                for (int k = 0; k < 4; k++) begin
                    dur_reg[k] <= '0;
                end
                raw_reg      <= bwa_level(in_code);
                res_sample_reg <= '0;
                res_lost_reg <= frame_full;
                res_adv_reg  <= !frame_full;
            end
            // one event inside the window
            ST_WALK_EV: begin
                if (ev_time < next_time_reg) begin
                    dur_reg[lv_reg] <= dur_reg[lv_reg] + (ev_clamp - cursor_reg);
                    cursor_reg      <= ev_clamp;
                    lv_reg          <= rd_level;
                    walk_n_reg      <= walk_n_reg + 1'b1;
                    rd_ptr_reg      <= ptr_inc(rd_ptr_reg);
                end
            end
            ST_TAIL: begin
                dur_reg[lv_reg] <= dur_reg[lv_reg] + (next_time_reg - cursor_reg);
                norm_sh_reg     <= norm_sh;
            end
            // shifted durations: denominator and weights
            ST_SUMS: begin
                den_reg  <= DEN_W'(sh_dur[0]) + DEN_W'(sh_dur[1])
                          + DEN_W'(sh_dur[2]) + DEN_W'(sh_dur[3]);
                wsum_reg <= 43'(sh_dur[1]) + {42'(sh_dur[2]), 1'b0};
                s3_reg   <= DEN_W'(sh_dur[3]);
            end
            ST_MUL_LO: begin
                raw_reg <= bwa_level(lv_reg);
                num_reg <= NUM_W'({15'd0, wsum_reg[21:0]} * {22'd0, LEVEL_THIRD})
                         + NUM_W'({s3_reg, 16'd0});
            end
            ST_MUL_HI: begin
                num_reg <= num_reg
                         + {{15'd0, wsum_reg[42:22]} * {21'd0, LEVEL_THIRD}, 22'd0};
            end
            ST_DIV: begin
                if (div_done) begin
                    raw_reg <= div_quot;
                end
            end
            ST_FILT_MUL: begin
                fprod_reg <= $signed({1'b0, alpha_reg}) * prev_out_reg;
            end
            ST_FILT_ADD: begin
                fout_reg <= fsat;
            end
            ST_SCALE_MUL: begin
                sprod_reg <= fmag * scale_reg;
            end
            // truncate toward zero and saturate
            ST_SCALE_SAT: begin
                if (fout_reg[FILT_W-1]) begin
                    res_sample_reg <= (sq > 24'd32768) ? 16'h8000 : 16'(-sq);
                end else begin
                    res_sample_reg <= (sq > 24'd32767) ? 16'h7FFF : sq[15:0];
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_sample_reg <= res_sample_reg;
                    m_index_reg  <= res_adv_reg ? 10'(frame_cnt_reg) : 10'd0;
                    m_lost_reg   <= res_lost_reg;
                    m_over_reg   <= lost_flag_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, m_over_reg, m_index_reg, m_sample_reg};
    assign m_tuser  = m_lost_reg;

endmodule

`default_nettype wire
